### hw/rtl/tsfc_pkg.sv
// Shared types, constants and saturating helpers for the trajectory cost block.
package tsfc_pkg;

  // Working value: every product and sum saturates to +-(2^62-1), so 63 bits hold it.
  typedef logic signed [62:0] val_t;
  typedef logic signed [47:0] grad_t;

  localparam int WINDOW_POINTS = 4;
  localparam int AXES          = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic signed [63:0] LIM64   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0]        LIM_U   = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] G48MAX  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] G48MIN  = -64'sh0000_8000_0000_0000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEAS_W    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LIM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_INT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USE_JERK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_END = 3'd6;

  // Register reset values.
  localparam logic [31:0] RST_SMOOTH_W = 32'd65536;
  localparam logic [31:0] RST_FEAS_W   = 32'd65536;
  localparam logic [30:0] RST_VEL_LIM  = 31'd196608;
  localparam logic [30:0] RST_ACC_LIM  = 31'd196608;
  localparam logic [31:0] RST_INV_INT  = 32'd655360;

  // Request to and response from the shared multiplier.
  typedef struct packed {
    logic go;
    val_t a;
    val_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    val_t prod;
  } mul_rsp_t;

  // Clamp a 64-bit signed value to +-(2^62-1).
  function automatic val_t clamp64(logic signed [63:0] s);
    val_t r;
    if (s > LIM64) begin
      r = LIM64[62:0];
    end else if (s < -LIM64) begin
      r = -$signed(LIM_U);
    end else begin
      r = s[62:0];
    end
    return r;
  endfunction

  function automatic val_t sadd(val_t a, val_t b);
    logic signed [63:0] s;
    s = $signed({a[62], a}) + $signed({b[62], b});
    return clamp64(s);
  endfunction

  // Saturating multiply by two, or by minus two when neg is set.
  function automatic val_t sat2(val_t x, logic neg);
    logic signed [63:0] d;
    d = $signed({x, 1'b0});
    if (neg) begin
      d = -d;
    end
    return clamp64(d);
  endfunction

  // Amount by which a value lies outside the band -lim..lim.
  function automatic val_t excess(val_t v, logic [30:0] lim);
    val_t l;
    val_t r;
    l = $signed({32'd0, lim});
    if (v > l) begin
      r = v - l;
    end else if (v < -l) begin
      r = v + l;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Pending gradient plus an increment, saturated to 48 bits.
  function automatic grad_t sat48(grad_t p, val_t add);
    logic signed [63:0] s;
    grad_t r;
    s = $signed({{16{p[47]}}, p}) + $signed({add[62], add});
    if (s > G48MAX) begin
      r = G48MAX[47:0];
    end else if (s < G48MIN) begin
      r = G48MIN[47:0];
    end else begin
      r = s[47:0];
    end
    return r;
  endfunction

  function automatic val_t sext32(logic [31:0] x);
    return $signed({{31{x[31]}}, x});
  endfunction

endpackage

### hw/rtl/tsfc_mul.sv
// Shared Q16.16 multiplier: four 32x32 partial products, truncation and saturation.
module tsfc_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  tsfc_pkg::mul_req_t req,
  output tsfc_pkg::mul_rsp_t rsp
);

  logic [62:0]  ua_r, ub_r;
  logic         neg_r;
  logic [2:0]   ph_r;
  logic         busy_r;
  logic         done_r;
  logic [63:0]  pp_r;
  logic [125:0] acc_r;
  tsfc_pkg::val_t prod_r;

  logic [31:0]  mx, my;
  logic [63:0]  pp_c;
  logic [125:0] addend;
  logic [95:0]  r96;
  logic         big;
  logic [62:0]  mag;
  tsfc_pkg::val_t fin;

  // Operand lanes for the partial product of this phase.
  always_comb begin
    case (ph_r)
      3'd2: begin
        mx = ua_r[31:0];
        my = {1'b0, ub_r[62:32]};
      end
      3'd3: begin
        mx = {1'b0, ua_r[62:32]};
        my = ub_r[31:0];
      end
      3'd4: begin
        mx = {1'b0, ua_r[62:32]};
        my = {1'b0, ub_r[62:32]};
      end
      default: begin
        mx = ua_r[31:0];
        my = ub_r[31:0];
      end
    endcase
  end

  assign pp_c = mx * my;

  // The partial product from the previous phase, placed at its weight.
  always_comb begin
    case (ph_r)
      3'd2:      addend = {62'd0, pp_r};
      3'd3,
      3'd4:      addend = {30'd0, pp_r, 32'd0};
      3'd5:      addend = {pp_r[61:0], 64'd0};
      default:   addend = '0;
    endcase
  end

  // Drop sixteen fraction bits, saturate the magnitude and restore the sign.
  always_comb begin
    r96 = acc_r[111:16];
    big = (|acc_r[125:112]) || (r96 > {33'd0, tsfc_pkg::LIM_U});
    mag = big ? tsfc_pkg::LIM_U : r96[62:0];
    fin = neg_r ? -$signed(mag) : $signed(mag);
  end

  // Phase control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        ph_r   <= 3'd1;
      end else if (busy_r) begin
        if (ph_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          ph_r   <= 3'd0;
        end else begin
          ph_r <= ph_r + 3'd1;
        end
      end
    end
  end

  // Operand magnitudes, partial products and the accumulator.
  always_ff @(posedge clk) begin
    if (req.go) begin
      ua_r  <= req.a[62] ? 63'(-req.a) : 63'(req.a);
      ub_r  <= req.b[62] ? 63'(-req.b) : 63'(req.b);
      neg_r <= req.a[62] ^ req.b[62];
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r  <= pp_c;
      acc_r <= acc_r + addend;
      if (ph_r == 3'd6) begin
        prod_r <= fin;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule

### hw/rtl/trajectory_smooth_feasibility_cost.sv
// Top level: point window, pending gradients, sequencer and result register.
//
// Control points enter on the in_ channel, one item per point, with
// in_last_point on the final point of a trajectory. in_stall is high while
// a point is being worked on. All arithmetic goes through one shared
// multiplier, whose products are issued by the sequencer.
// A point needs 28 products when no term applies (the first point of a
// trajectory) and up to 52 with all smoothness and limit terms active;
// a skipped step issues no product. Emitting visits one window slot, or
// four on the last point, and a final step finishes the point.
// Once four points are held each point yields one gradient item on the
// out_ channel; the last point flushes up to four, the final one flagged by
// out_last_result, and then the trajectory state returns to zero.
// A gradient sits in the output register until taken; a stalled receiver
// holds back the sequencer only when a further gradient is due.
// The cfg_ port writes one register per cycle and should be used only while
// the block is idle. Synchronous reset loads the register defaults and
// clears the window, the pending gradients and the running cost.
module trajectory_smooth_feasibility_cost (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  in_pos_x,
  input  logic signed [31:0]                  in_pos_y,
  input  logic signed [31:0]                  in_pos_z,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [47:0]                  out_grad_x,
  output logic signed [47:0]                  out_grad_y,
  output logic signed [47:0]                  out_grad_z,
  output logic [62:0]                         out_total_cost,
  output logic                                out_last_result,
  input  logic                                cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_TS2  = 5'd1;
  localparam logic [4:0] ST_TS3  = 5'd2;
  localparam logic [4:0] ST_SM   = 5'd3;
  localparam logic [4:0] ST_VEL  = 5'd4;
  localparam logic [4:0] ST_VG   = 5'd5;
  localparam logic [4:0] ST_VE   = 5'd6;
  localparam logic [4:0] ST_VC   = 5'd7;
  localparam logic [4:0] ST_ACC  = 5'd8;
  localparam logic [4:0] ST_AG   = 5'd9;
  localparam logic [4:0] ST_AE   = 5'd10;
  localparam logic [4:0] ST_WS   = 5'd11;
  localparam logic [4:0] ST_WF   = 5'd12;
  localparam logic [4:0] ST_CS   = 5'd13;
  localparam logic [4:0] ST_CF   = 5'd14;
  localparam logic [4:0] ST_EMIT = 5'd15;
  localparam logic [4:0] ST_FIN  = 5'd16;

  // Configuration registers.
  logic [31:0] sw_r, fw_r, inv_r;
  logic [30:0] vl_r, al_r;
  logic        uj_r, ce_r;

  // Trajectory state.
  logic signed [31:0] win_r   [0:3][0:2];
  logic signed [31:0] win_nxt [0:3][0:2];
  tsfc_pkg::grad_t    pend_r  [0:3][0:2];
  tsfc_pkg::grad_t    pend_nxt[0:3][0:2];
  logic [62:0]        cost_r;
  logic [2:0]         seen_r;

  // Sequencer.
  logic [4:0] state_r, state_nxt;
  logic       wait_r;
  logic [1:0] k_r, s_r, em_r;
  logic [2:0] n_r;
  logic       last_r;

  // Working values.
  tsfc_pkg::val_t ts2_r, ts3_r, e_r, tmp_r, cs_r, cf_r;
  tsfc_pkg::val_t gs_r [0:3];
  tsfc_pkg::val_t gf_r [0:3];

  tsfc_pkg::mul_req_t mul_req;
  tsfc_pkg::mul_rsp_t mul_rsp;

  logic           accept, wb, adv, skip, is_op, mul_go;
  tsfc_pkg::val_t op_a, op_b;
  tsfc_pkg::val_t q0, q1, q2, q3, jv, av, dv, tv_j, tv_a;
  tsfc_pkg::val_t inv_v, ex_val, prod, cadd;
  logic [30:0]    ex_lim;
  logic [63:0]    cost_sum;
  logic [1:0]     first_slot;
  logic           can_load, in_range, emit_load, emit_shift, emit_done, grad_zero;
  logic [3:0]     n_plus_s;
  logic           out_valid_r;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign prod     = mul_rsp.prod;
  assign wb       = wait_r && mul_rsp.done;
  assign inv_v    = $signed({31'd0, inv_r});

  // Differences along the current axis, always held in column zero.
  always_comb begin
    q0   = tsfc_pkg::sext32(win_r[0][0]);
    q1   = tsfc_pkg::sext32(win_r[1][0]);
    q2   = tsfc_pkg::sext32(win_r[2][0]);
    q3   = tsfc_pkg::sext32(win_r[3][0]);
    jv   = q3 - ((q2 <<< 1) + q2) + ((q1 <<< 1) + q1) - q0;
    av   = q3 - (q2 <<< 1) + q1;
    dv   = q3 - q2;
    tv_j = jv <<< 1;
    tv_a = av <<< 1;
  end

  // Operand selection and term skipping for each multiply step.
  always_comb begin
    op_a = '0;
    op_b = '0;
    skip = 1'b0;
    case (state_r)
      ST_TS2: begin
        op_a = inv_v;
        op_b = inv_v;
      end
      ST_TS3: begin
        op_a = ts2_r;
        op_b = inv_v;
      end
      ST_SM: begin
        skip = uj_r ? (n_r < 3'd3) : (n_r < 3'd2);
        op_a = uj_r ? jv : av;
        op_b = uj_r ? jv : av;
      end
      ST_VEL: begin
        skip = (n_r < 3'd1);
        op_a = dv;
        op_b = inv_v;
      end
      ST_VG: begin
        op_a = tsfc_pkg::sat2(e_r, 1'b0);
        op_b = ts3_r;
      end
      ST_VE, ST_AE: begin
        op_a = e_r;
        op_b = e_r;
      end
      ST_VC: begin
        op_a = tmp_r;
        op_b = ts2_r;
      end
      ST_ACC: begin
        skip = (n_r < 3'd2);
        op_a = av;
        op_b = ts2_r;
      end
      ST_AG: begin
        op_a = tsfc_pkg::sat2(e_r, 1'b0);
        op_b = ts2_r;
      end
      ST_WS: begin
        op_a = $signed({31'd0, sw_r});
        op_b = gs_r[0];
      end
      ST_WF: begin
        op_a = $signed({31'd0, fw_r});
        op_b = gf_r[0];
      end
      ST_CS: begin
        op_a = $signed({31'd0, sw_r});
        op_b = cs_r;
      end
      ST_CF: begin
        op_a = $signed({31'd0, fw_r});
        op_b = cf_r;
      end
      default: begin
        skip = 1'b0;
      end
    endcase
  end

  assign is_op  = (state_r >= ST_TS2) && (state_r <= ST_CF);
  assign mul_go = is_op && !wait_r && !skip;
  assign adv    = is_op && !wait_r && skip;

  assign mul_req.go = mul_go;
  assign mul_req.a  = op_a;
  assign mul_req.b  = op_b;

  tsfc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // Limit check shared by the velocity and acceleration terms.
  assign ex_lim = (state_r == ST_VEL) ? vl_r : al_r;
  assign ex_val = tsfc_pkg::excess(prod, ex_lim);

  // Weighted cost increment and running total.
  always_comb begin
    cadd     = tsfc_pkg::sadd(tmp_r, prod);
    cost_sum = {1'b0, cost_r} + (cadd[62] ? 64'd0 : {1'b0, cadd[62:0]});
  end

  // Emission of the held gradients.
  always_comb begin
    first_slot = (last_r && (n_r < 3'd3)) ? 2'(3'd3 - n_r) : 2'd0;
    can_load   = !out_valid_r || !out_stall;
    in_range   = (em_r >= first_slot);
    emit_load  = (state_r == ST_EMIT) && in_range && can_load;
    emit_shift = (state_r == ST_EMIT) && last_r && (!in_range || can_load);
    emit_done  = emit_load && (!last_r || (em_r == 2'd3));
    n_plus_s   = {1'b0, n_r} + {2'b0, em_r};
    grad_zero  = ce_r && ((n_plus_s < 4'd6) || (last_r && (em_r >= 2'd2)));
  end

  // Next step of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_TS2;
      ST_TS2:  if (wb) state_nxt = ST_TS3;
      ST_TS3:  if (wb) state_nxt = ST_SM;
      ST_SM:   if (wb || adv) state_nxt = ST_VEL;
      ST_VEL: begin
        if (adv) begin
          state_nxt = ST_ACC;
        end else if (wb) begin
          state_nxt = (ex_val == '0) ? ST_ACC : ST_VG;
        end
      end
      ST_VG:   if (wb) state_nxt = ST_VE;
      ST_VE:   if (wb) state_nxt = ST_VC;
      ST_VC:   if (wb) state_nxt = ST_ACC;
      ST_ACC: begin
        if (adv) begin
          state_nxt = ST_WS;
        end else if (wb) begin
          state_nxt = (ex_val == '0) ? ST_WS : ST_AG;
        end
      end
      ST_AG:   if (wb) state_nxt = ST_AE;
      ST_AE:   if (wb) state_nxt = ST_WS;
      ST_WS:   if (wb) state_nxt = ST_WF;
      ST_WF: begin
        if (wb) begin
          if (s_r == 2'd3) begin
            state_nxt = (k_r == 2'd2) ? ST_CS : ST_SM;
          end else begin
            state_nxt = ST_WS;
          end
        end
      end
      ST_CS:   if (wb) state_nxt = ST_CF;
      ST_CF: begin
        if (wb) begin
          state_nxt = (last_r || (n_r >= 3'd3)) ? ST_EMIT : ST_FIN;
        end
      end
      ST_EMIT: if (emit_done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Window: new point at the back, axis rotation after each axis, clear at the end.
  always_comb begin
    win_nxt = win_r;
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[3][0] = in_pos_x;
      win_nxt[3][1] = in_pos_y;
      win_nxt[3][2] = in_pos_z;
    end
    if ((state_r == ST_WF) && wb && (s_r == 2'd3)) begin
      for (int i = 0; i < 4; i++) begin
        win_nxt[i][0] = win_r[i][1];
        win_nxt[i][1] = win_r[i][2];
        win_nxt[i][2] = win_r[i][0];
      end
    end
    if ((state_r == ST_FIN) && last_r) begin
      win_nxt = '{default: '0};
    end
  end

  // Pending gradients: the slot being weighted cycles through the front of column zero.
  always_comb begin
    tsfc_pkg::grad_t rot [0:3][0:2];
    pend_nxt = pend_r;
    rot      = pend_r;
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        pend_nxt[i] = pend_r[i + 1];
      end
      pend_nxt[3] = '{default: '0};
    end
    if ((state_r == ST_WF) && wb) begin
      for (int i = 0; i < 3; i++) begin
        rot[i][0] = pend_r[i + 1][0];
      end
      rot[3][0] = tsfc_pkg::sat48(pend_r[0][0], tsfc_pkg::sadd(tmp_r, prod));
      pend_nxt  = rot;
      if (s_r == 2'd3) begin
        for (int i = 0; i < 4; i++) begin
          pend_nxt[i][0] = rot[i][1];
          pend_nxt[i][1] = rot[i][2];
          pend_nxt[i][2] = rot[i][0];
        end
      end
    end
    if (emit_shift) begin
      for (int i = 0; i < 3; i++) begin
        pend_nxt[i] = pend_r[i + 1];
      end
      pend_nxt[3] = '{default: '0};
    end
    if ((state_r == ST_FIN) && last_r) begin
      pend_nxt = '{default: '0};
    end
  end

  // Control state, configuration and trajectory state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= 1'b0;
      k_r         <= 2'd0;
      s_r         <= 2'd0;
      em_r        <= 2'd0;
      n_r         <= 3'd0;
      last_r      <= 1'b0;
      seen_r      <= 3'd0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
      win_r       <= '{default: '0};
      pend_r      <= '{default: '0};
      sw_r        <= tsfc_pkg::RST_SMOOTH_W;
      fw_r        <= tsfc_pkg::RST_FEAS_W;
      vl_r        <= tsfc_pkg::RST_VEL_LIM;
      al_r        <= tsfc_pkg::RST_ACC_LIM;
      inv_r       <= tsfc_pkg::RST_INV_INT;
      uj_r        <= 1'b1;
      ce_r        <= 1'b1;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      pend_r  <= pend_nxt;

      if (mul_go) begin
        wait_r <= 1'b1;
      end else if (wb) begin
        wait_r <= 1'b0;
      end

      if (accept) begin
        n_r    <= seen_r;
        last_r <= in_last_point;
        k_r    <= 2'd0;
        s_r    <= 2'd0;
      end

      // Slot and axis counters of the weighting pass.
      if ((state_r == ST_WF) && wb) begin
        s_r <= s_r + 2'd1;
        if (s_r == 2'd3) begin
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
      end

      if ((state_r == ST_CF) && wb) begin
        cost_r <= cost_sum[63] ? '1 : cost_sum[62:0];
        em_r   <= 2'd0;
      end

      if (emit_shift) begin
        em_r <= em_r + 2'd1;
      end

      // End of the point: clear after the last one, otherwise count it.
      if (state_r == ST_FIN) begin
        if (last_r) begin
          seen_r <= 3'd0;
          cost_r <= '0;
        end else begin
          seen_r <= (n_r == 3'd7) ? 3'd7 : n_r + 3'd1;
        end
      end

      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          tsfc_pkg::REG_SMOOTH_W:  sw_r  <= cfg_wdata;
          tsfc_pkg::REG_FEAS_W:    fw_r  <= cfg_wdata;
          tsfc_pkg::REG_VEL_LIM:   vl_r  <= cfg_wdata[30:0];
          tsfc_pkg::REG_ACC_LIM:   al_r  <= cfg_wdata[30:0];
          tsfc_pkg::REG_INV_INT:   inv_r <= cfg_wdata;
          tsfc_pkg::REG_USE_JERK:  uj_r  <= cfg_wdata[0];
          tsfc_pkg::REG_CLAMP_END: ce_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working values written back from the multiplier.
  always_ff @(posedge clk) begin
    if (accept) begin
      cs_r <= '0;
      cf_r <= '0;
    end
    if (adv && (state_r == ST_SM)) begin
      gs_r <= '{default: '0};
      gf_r <= '{default: '0};
    end
    if (wb) begin
      case (state_r)
        ST_TS2: ts2_r <= prod;
        ST_TS3: ts3_r <= prod;
        ST_SM: begin
          cs_r <= tsfc_pkg::sadd(cs_r, prod);
          gf_r <= '{default: '0};
          if (uj_r) begin
            gs_r[0] <= -tv_j;
            gs_r[1] <= (tv_j <<< 1) + tv_j;
            gs_r[2] <= -((tv_j <<< 1) + tv_j);
            gs_r[3] <= tv_j;
          end else begin
            gs_r[0] <= '0;
            gs_r[1] <= tv_a;
            gs_r[2] <= -(tv_a <<< 1);
            gs_r[3] <= tv_a;
          end
        end
        ST_VEL, ST_ACC: e_r <= ex_val;
        ST_VG: begin
          gf_r[2] <= tsfc_pkg::sadd(gf_r[2], -prod);
          gf_r[3] <= tsfc_pkg::sadd(gf_r[3], prod);
        end
        ST_VE, ST_WS, ST_CS: tmp_r <= prod;
        ST_VC, ST_AE: cf_r <= tsfc_pkg::sadd(cf_r, prod);
        ST_AG: begin
          gf_r[1] <= tsfc_pkg::sadd(gf_r[1], prod);
          gf_r[2] <= tsfc_pkg::sadd(gf_r[2], tsfc_pkg::sat2(prod, 1'b1));
          gf_r[3] <= tsfc_pkg::sadd(gf_r[3], prod);
        end
        ST_WF: begin
          for (int i = 0; i < 3; i++) begin
            gs_r[i] <= gs_r[i + 1];
            gf_r[i] <= gf_r[i + 1];
          end
          gs_r[3] <= '0;
          gf_r[3] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_grad_x      <= grad_zero ? '0 : pend_r[0][0];
      out_grad_y      <= grad_zero ? '0 : pend_r[0][1];
      out_grad_z      <= grad_zero ? '0 : pend_r[0][2];
      out_total_cost  <= cost_r;
      out_last_result <= last_r && (em_r == 2'd3);
    end
  end

  assign out_valid = out_valid_r;

  // A product comes back only for a step that is waiting on it.
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> wait_r)
    else $error("multiplier result without a waiting step");

  // An accepted point holds off the next one.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken again straight after a point");

  // The idle sequencer has no product outstanding.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wait_r)
    else $error("multiply outstanding while idle");

  // A loaded gradient is offered on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> out_valid)
    else $error("gradient loaded but not offered");

endmodule
